// File: src/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg: shared types and constants for gradient non-maximum suppression
// Widths of the gradient and magnitude fields, direction bins and the
// fixed-point tangent thresholds used to sort gradient direction.
// ----------------------------------------------------------------------------
package gnms_pkg;

	localparam int GRAD_W = 11;
	localparam int MAG_W = 12;
	localparam int SUM_W = 2 * GRAD_W + 1;
	localparam int PROD_W = GRAD_W + 26;
	localparam int LANES = 3;
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = 11;
	localparam int HGT_W = 12;

	// tan 22.5 and tan 67.5 degrees with 24 fraction bits.
	localparam logic [25:0] TAN_LOW = 26'd6949350;
	localparam logic [25:0] TAN_HIGH = 26'd40503782;

	typedef enum logic [1:0] {
		BIN_H = 2'd0,
		BIN_D = 2'd1,
		BIN_V = 2'd2
	} bin_t;

	typedef logic [LANES-1:0][MAG_W-1:0] mag3_t;
	typedef bin_t [LANES-1:0] bin3_t;

	localparam int LINE_W = 2 * LANES * MAG_W + 2 * LANES;

	// Configuration register indexes.
	localparam logic CFG_WIDTH = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

endpackage

// File: src/gnms_if.sv
// ----------------------------------------------------------------------------
// gnms_if: stream channels of the suppression core
// Input channel carries one pixel of x and y gradients for three colors;
// output channel carries one word of suppressed magnitudes.
// ----------------------------------------------------------------------------
interface gnms_in_if;
	logic valid;
	logic ready;
	logic [10:0] x_red;
	logic [10:0] y_red;
	logic [10:0] x_green;
	logic [10:0] y_green;
	logic [10:0] x_blue;
	logic [10:0] y_blue;

	modport source (output valid, x_red, y_red, x_green, y_green, x_blue, y_blue,
		input ready);
	modport sink (input valid, x_red, y_red, x_green, y_green, x_blue, y_blue,
		output ready);
endinterface

interface gnms_out_if;
	logic valid;
	logic ready;
	logic [11:0] edge_red;
	logic [11:0] edge_green;
	logic [11:0] edge_blue;
	logic frame_last;

	modport source (output valid, edge_red, edge_green, edge_blue, frame_last,
		input ready);
	modport sink (input valid, edge_red, edge_green, edge_blue, frame_last,
		output ready);
endinterface

// File: src/gnms_ram.sv
// ----------------------------------------------------------------------------
// gnms_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/gnms_lane.sv
// ----------------------------------------------------------------------------
// gnms_lane: magnitude and direction bin of one color channel
// Squares and tangent products in the MUL1 and MUL2 states, then the
// direction bin and a bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gnms_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gnms_pkg::GRAD_W-1:0] gx,
	input  logic [gnms_pkg::GRAD_W-1:0] gy,
	output logic                       done,
	output logic [gnms_pkg::MAG_W-1:0]  mag,
	output gnms_pkg::bin_t             dir
);

	typedef enum logic [2:0] {L_IDLE, L_MUL1, L_MUL2, L_BIN, L_ROOT, L_DONE} lstate_t;

	lstate_t                         state_q;
	logic [gnms_pkg::GRAD_W-1:0]     gx_q;
	logic [gnms_pkg::GRAD_W-1:0]     gy_q;
	logic [gnms_pkg::SUM_W-1:0]      acc_q;
	logic [gnms_pkg::SUM_W-1:0]      root_q;
	logic [gnms_pkg::SUM_W-1:0]      bit_q;
	logic [gnms_pkg::PROD_W-1:0]     prod_q;
	logic                            lo_hit_q;
	gnms_pkg::bin_t                  dir_q;

	logic [gnms_pkg::PROD_W-1:0] gy_shl;
	logic [gnms_pkg::SUM_W-1:0]  trial;

	assign gy_shl = {{(gnms_pkg::PROD_W-gnms_pkg::GRAD_W-24){1'b0}}, gy_q, 24'd0};
	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						gx_q <= gx;
						gy_q <= gy;
						state_q <= L_MUL1;
					end
				end
				L_MUL1: begin
					acc_q <= gnms_pkg::SUM_W'(gx_q * gx_q);
					prod_q <= gnms_pkg::PROD_W'(gx_q * gnms_pkg::TAN_LOW);
					state_q <= L_MUL2;
				end
				L_MUL2: begin
					acc_q <= acc_q + gnms_pkg::SUM_W'(gy_q * gy_q);
					lo_hit_q <= gy_shl < prod_q;
					prod_q <= gnms_pkg::PROD_W'(gx_q * gnms_pkg::TAN_HIGH);
					state_q <= L_BIN;
				end
				L_BIN: begin
					if (gx_q == '0 && gy_q == '0) begin
						dir_q <= gnms_pkg::BIN_H;
					end else if (lo_hit_q) begin
						dir_q <= gnms_pkg::BIN_H;
					end else if (gy_shl < prod_q) begin
						dir_q <= gnms_pkg::BIN_D;
					end else begin
						dir_q <= gnms_pkg::BIN_V;
					end
					root_q <= '0;
					bit_q <= gnms_pkg::SUM_W'(1) << (gnms_pkg::SUM_W - 1);
					state_q <= L_ROOT;
				end
				L_ROOT: begin
					if (acc_q >= trial) begin
						acc_q <= acc_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign done = state_q == L_DONE;
	assign mag = root_q[gnms_pkg::MAG_W-1:0];
	assign dir = dir_q;

endmodule

// File: src/gradient_nonmax_suppression_core.sv
// ----------------------------------------------------------------------------
// gradient_nonmax_suppression_core: three-color gradient non-maximum suppression
// Streams gradient pixels in raster order and emits suppressed magnitudes
// for the interior pixels of each frame.
// ----------------------------------------------------------------------------
// The core takes a new pixel word only once the previous one has been
// fully processed. Three color lanes run side by side, and the lane sequence
// sets the pace: the accepting cycle, squares and tangent products, the
// direction bin, a bit-pair square root (one result bit per cycle) and
// the lane done state. The update step then writes the shared line buffer,
// shifts the 3x3 window and loads the output register, which holds a finished
// word while the next pixel is accepted. That update step waits only while
// an earlier word is still held and the receiver is not ready.
// An output word appears only for interior pixels (not in the first or last
// row or column); frame_last marks the final interior pixel of a frame.
// The line buffer needs no clearing after reset. Width and height should be
// written only between frames while the core is idle.
module gradient_nonmax_suppression_core (
	input  logic                       clk,
	input  logic                       arst_n,
	gnms_in_if.sink                    pix_in,
	gnms_out_if.source                 edge_out,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [gnms_pkg::HGT_W-1:0] cfg_data
);

	typedef enum logic [1:0] {S_IDLE, S_WAIT, S_UPDATE} state_t;

	state_t state_q;

	// Configuration registers.
	logic [gnms_pkg::WID_W-1:0] width_q;
	logic [gnms_pkg::HGT_W-1:0] height_q;

	// Raster position of the pixel being processed.
	logic [gnms_pkg::COL_W-1:0] col_q;
	logic [gnms_pkg::HGT_W-1:0] row_q;

	// 3x3 magnitude window, [row][column], row 2 and column 2 newest.
	// dir0_q holds the bins read from the line buffer one pixel ago; after
	// the next shift they belong to the window center.
	gnms_pkg::mag3_t win_q [3][3];
	gnms_pkg::bin3_t dir0_q;

	// Output word register.
	logic                       out_vld_q;
	gnms_pkg::mag3_t            out_mag_q;
	logic                       out_last_q;

	// Lane signals.
	logic [gnms_pkg::LANES-1:0]                     lane_done;
	gnms_pkg::mag3_t                                lane_mag;
	gnms_pkg::bin3_t                                lane_dir;
	logic [gnms_pkg::LANES-1:0][gnms_pkg::GRAD_W-1:0] gx_in;
	logic [gnms_pkg::LANES-1:0][gnms_pkg::GRAD_W-1:0] gy_in;

	// Line buffer word: direction bins, row above, row two above.
	logic [gnms_pkg::LINE_W-1:0] line_rd;
	logic [gnms_pkg::LINE_W-1:0] line_wr;
	gnms_pkg::mag3_t             buf_above;
	gnms_pkg::mag3_t             buf_two_above;
	gnms_pkg::bin3_t             buf_dir;

	logic accept;
	logic proceed;
	logic emit;
	logic [gnms_pkg::WID_W-1:0] w_eff;
	logic [gnms_pkg::HGT_W-1:0] h_eff;
	logic row_end;
	logic frame_end;
	gnms_pkg::mag3_t kept;

	assign accept = pix_in.valid && pix_in.ready;
	assign pix_in.ready = state_q == S_IDLE;

	assign gx_in = {pix_in.x_blue, pix_in.x_green, pix_in.x_red};
	assign gy_in = {pix_in.y_blue, pix_in.y_green, pix_in.y_red};

	// The color lanes run in lockstep from the same start.
	for (genvar ch = 0; ch < gnms_pkg::LANES; ch++) begin : g_lane
		gnms_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.gx     (gx_in[ch]),
			.gy     (gy_in[ch]),
			.done   (lane_done[ch]),
			.mag    (lane_mag[ch]),
			.dir    (lane_dir[ch])
		);
	end

	assign buf_two_above = line_rd[gnms_pkg::LANES*gnms_pkg::MAG_W-1:0];
	assign buf_above = line_rd[2*gnms_pkg::LANES*gnms_pkg::MAG_W-1:
		gnms_pkg::LANES*gnms_pkg::MAG_W];
	assign buf_dir = gnms_pkg::bin3_t'(line_rd[gnms_pkg::LINE_W-1:
		2*gnms_pkg::LANES*gnms_pkg::MAG_W]);
	assign line_wr = {lane_dir, lane_mag, buf_above};

	// The line buffer is read when a pixel is accepted and written back at
	// the same column once the lanes are done.
	gnms_ram #(
		.WIDTH (gnms_pkg::LINE_W),
		.DEPTH (gnms_pkg::MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (proceed),
		.waddr (col_q),
		.wdata (line_wr),
		.re    (accept),
		.raddr (col_q),
		.rdata (line_rd)
	);

	// Sizes outside the supported range act as the nearest legal size.
	always_comb begin
		if (width_q < gnms_pkg::WID_W'(3)) begin
			w_eff = gnms_pkg::WID_W'(3);
		end else if (width_q > gnms_pkg::WID_W'(gnms_pkg::MAX_WIDTH)) begin
			w_eff = gnms_pkg::WID_W'(gnms_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff = (height_q < gnms_pkg::HGT_W'(3)) ? gnms_pkg::HGT_W'(3) : height_q;
	end

	assign row_end = ({1'b0, col_q} + gnms_pkg::WID_W'(1)) >= w_eff;
	assign frame_end = ({1'b0, row_q} + (gnms_pkg::HGT_W+1)'(1)) >= {1'b0, h_eff};
	assign emit = row_q >= gnms_pkg::HGT_W'(2) && col_q >= gnms_pkg::COL_W'(2)
		&& row_q < h_eff && {1'b0, col_q} < w_eff;

	// The update waits only if a finished word is still held and not taken.
	assign proceed = state_q == S_UPDATE && (!out_vld_q || edge_out.ready);

	// Merging stage: each channel compares the window center, after the
	// shift, with its two neighbors along the center's direction bin.
	for (genvar ch = 0; ch < gnms_pkg::LANES; ch++) begin : g_sup
		logic [gnms_pkg::MAG_W-1:0] cen;
		logic [gnms_pkg::MAG_W-1:0] na;
		logic [gnms_pkg::MAG_W-1:0] nb;
		always_comb begin
			cen = win_q[1][2][ch];
			case (dir0_q[ch])
				gnms_pkg::BIN_H: begin
					na = win_q[1][1][ch];
					nb = buf_above[ch];
				end
				gnms_pkg::BIN_D: begin
					na = lane_mag[ch];
					nb = win_q[0][1][ch];
				end
				default: begin
					na = win_q[2][2][ch];
					nb = win_q[0][2][ch];
				end
			endcase
			kept[ch] = (cen > na && cen > nb) ? cen : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= gnms_pkg::WID_W'(640);
			height_q <= gnms_pkg::HGT_W'(480);
			col_q <= '0;
			row_q <= '0;
			out_vld_q <= 1'b0;
			dir0_q <= gnms_pkg::bin3_t'('0);
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gnms_pkg::CFG_WIDTH: width_q <= cfg_data[gnms_pkg::WID_W-1:0];
					gnms_pkg::CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			// A new word may be loaded in the same cycle the held one is taken.
			if (proceed && emit) begin
				out_vld_q <= 1'b1;
			end else if (edge_out.valid && edge_out.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (lane_done[0]) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (proceed) begin
						for (int r = 0; r < 3; r++) begin
							win_q[r][0] <= win_q[r][1];
							win_q[r][1] <= win_q[r][2];
						end
						win_q[0][2] <= buf_two_above;
						win_q[1][2] <= buf_above;
						win_q[2][2] <= lane_mag;
						dir0_q <= buf_dir;
						if (emit) begin
							out_mag_q <= kept;
							out_last_q <= row_q == h_eff - gnms_pkg::HGT_W'(1)
								&& {1'b0, col_q} == w_eff - gnms_pkg::WID_W'(1);
						end
						if (row_end) begin
							col_q <= '0;
							row_q <= frame_end ? '0 : row_q + gnms_pkg::HGT_W'(1);
						end else begin
							col_q <= col_q + gnms_pkg::COL_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign edge_out.valid = out_vld_q;
	assign edge_out.edge_red = out_mag_q[0];
	assign edge_out.edge_green = out_mag_q[1];
	assign edge_out.edge_blue = out_mag_q[2];
	assign edge_out.frame_last = out_last_q;

	// The three lanes start together and must finish together.
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
		else $error("color lanes out of step");

	// A completed update frees the core for the next pixel word.
	a_update_frees: assert property (@(posedge clk) disable iff (!arst_n)
		proceed |=> pix_in.ready)
		else $error("core not ready after update");

	// Lanes finish only while the core waits on them.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done[0] |-> state_q == S_WAIT)
		else $error("lane finished outside the wait state");

endmodule

// File: tb/tb_gnms_scoreboard.sv
// ----------------------------------------------------------------------------
// tb_gnms_scoreboard: predictor and result checker for the suppression core
// Mirrors the line buffers, 3x3 window and position counters of the core,
// queues the word each accepted pixel should produce and checks output words.
// ----------------------------------------------------------------------------
package tb_gnms_sb_pkg;

	typedef struct packed {
		logic [11:0] red;
		logic [11:0] green;
		logic [11:0] blue;
		logic        last;
	} edge_word_t;

	class edge_scoreboard;
		logic [10:0] width_reg;
		logic [11:0] height_reg;
		logic [11:0] row_above [gnms_pkg::MAX_WIDTH][3];
		logic [11:0] row_two_above [gnms_pkg::MAX_WIDTH][3];
		gnms_pkg::bin_t bin_above [gnms_pkg::MAX_WIDTH][3];
		logic [11:0] window [3][3][3];
		gnms_pkg::bin_t center_bin [2][3];
		int unsigned col_pos;
		int unsigned row_pos;
		edge_word_t  expected_words[$];
		int unsigned mismatches;
		int unsigned words_checked;
		int unsigned nonzero_edges;
		int unsigned frames_closed;

		function new();
			width_reg = 11'd640;
			height_reg = 12'd480;
			foreach (window[i, j, k]) window[i][j][k] = '0;
			foreach (center_bin[i, k]) center_bin[i][k] = gnms_pkg::BIN_H;
			col_pos = 0;
			row_pos = 0;
			mismatches = 0;
			words_checked = 0;
			nonzero_edges = 0;
			frames_closed = 0;
		endfunction

		function void set_size(logic index, logic [11:0] value);
			if (index == gnms_pkg::CFG_WIDTH)
				width_reg = value[10:0];
			else
				height_reg = value;
		endfunction

		static function logic [11:0] root_floor(longint unsigned v);
			longint unsigned root = 0;
			longint unsigned bit_pos = 64'd1 << 24;
			while (bit_pos > v) bit_pos >>= 2;
			while (bit_pos != 0) begin
				if (v >= root + bit_pos) begin
					v -= root + bit_pos;
					root = (root >> 1) + bit_pos;
				end else begin
					root >>= 1;
				end
				bit_pos >>= 2;
			end
			return root[11:0];
		endfunction

		static function gnms_pkg::bin_t sort_bin(longint unsigned gx, longint unsigned gy);
			longint unsigned scaled = gy << 24;
			if (gx == 0 && gy == 0) return gnms_pkg::BIN_H;
			if (scaled < gx * gnms_pkg::TAN_LOW) return gnms_pkg::BIN_H;
			if (scaled < gx * gnms_pkg::TAN_HIGH) return gnms_pkg::BIN_D;
			return gnms_pkg::BIN_V;
		endfunction

		function logic [11:0] thin(int ch, gnms_pkg::bin_t b);
			logic [11:0] c = window[1][1][ch];
			logic [11:0] a, z;
			case (b)
				gnms_pkg::BIN_H: begin
					a = window[1][0][ch];
					z = window[1][2][ch];
				end
				gnms_pkg::BIN_D: begin
					a = window[2][2][ch];
					z = window[0][0][ch];
				end
				default: begin
					a = window[2][1][ch];
					z = window[0][1][ch];
				end
			endcase
			return (c > a && c > z) ? c : 12'd0;
		endfunction

		// Called once per accepted pixel; queues the word it should cause.
		function void note_pixel(logic [10:0] grad [6]);
			int unsigned w = width_reg;
			int unsigned h = height_reg;
			int unsigned c = col_pos;
			int unsigned r = row_pos;
			int unsigned col = col_pos % gnms_pkg::MAX_WIDTH;
			logic [11:0] mag [3];
			gnms_pkg::bin_t dir [3];
			edge_word_t word;
			if (w < 3) w = 3;
			if (w > gnms_pkg::MAX_WIDTH) w = gnms_pkg::MAX_WIDTH;
			if (h < 3) h = 3;
			for (int ch = 0; ch < 3; ch++) begin
				longint unsigned gx = grad[2*ch];
				longint unsigned gy = grad[2*ch+1];
				mag[ch] = root_floor(gx * gx + gy * gy);
				dir[ch] = sort_bin(gx, gy);
			end
			for (int k = 0; k < 3; k++)
				for (int ch = 0; ch < 3; ch++) begin
					window[k][0][ch] = window[k][1][ch];
					window[k][1][ch] = window[k][2][ch];
				end
			for (int ch = 0; ch < 3; ch++) begin
				window[0][2][ch] = row_two_above[col][ch];
				window[1][2][ch] = row_above[col][ch];
				window[2][2][ch] = mag[ch];
				center_bin[1][ch] = center_bin[0][ch];
				center_bin[0][ch] = bin_above[col][ch];
				row_two_above[col][ch] = row_above[col][ch];
				row_above[col][ch] = mag[ch];
				bin_above[col][ch] = dir[ch];
			end
			if (r >= 2 && c >= 2 && r < h && c < w) begin
				word.red = thin(0, center_bin[1][0]);
				word.green = thin(1, center_bin[1][1]);
				word.blue = thin(2, center_bin[1][2]);
				word.last = (r == h - 1 && c == w - 1);
				expected_words.insert(expected_words.size(), word);
			end
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_word(edge_word_t got);
			edge_word_t exp_w;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected edge word r=%0d g=%0d b=%0d last=%0b",
						got.red, got.green, got.blue, got.last);
				return;
			end
			exp_w = expected_words.pop_front();
			words_checked++;
			if (got.red != 0 || got.green != 0 || got.blue != 0) nonzero_edges++;
			if (got.last) frames_closed++;
			if (got !== exp_w) begin
				mismatches++;
				if (mismatches <= 10)
					$display("word %0d: exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
						words_checked, exp_w.red, exp_w.green, exp_w.blue, exp_w.last,
						got.red, got.green, got.blue, got.last);
			end
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction
	endclass
endpackage

// File: tb/tb_gradient_nonmax_suppression_core.sv
// ----------------------------------------------------------------------------
// tb_gradient_nonmax_suppression_core: self-checking bench for the core
// Streams gradient frames of several sizes, including out-of-range register
// values, under random sender and receiver stalls, and checks every output
// word against a cycle-free predictor of the suppression.
// ----------------------------------------------------------------------------
module tb_gradient_nonmax_suppression_core;
	timeunit 1ns;
	timeprecision 1ps;

	// The core finishes each pixel before taking the next; a frame edge pixel
	// gives no word, so settling waits span a few pixel times.
	localparam int SETTLE_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [gnms_pkg::HGT_W-1:0] cfg_data;

	gnms_in_if pix ();
	gnms_out_if eo ();

	gradient_nonmax_suppression_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix_in   (pix),
		.edge_out (eo),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	tb_gnms_sb_pkg::edge_scoreboard sb;
	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	int unsigned pixels_sent;
	int unsigned cycle_count;
	bit held_for_drain;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run guard: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// The receiver stalls at random; ready is redrawn at every edge.
	always @(posedge clk) begin
		if (!arst_n)
			eo.ready <= 1'b0;
		else
			eo.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Output words are taken at the edge where valid and ready are both high.
	always @(posedge clk) begin
		tb_gnms_sb_pkg::edge_word_t got;
		if (arst_n && eo.valid && eo.ready) begin
			got.red = eo.edge_red;
			got.green = eo.edge_green;
			got.blue = eo.edge_blue;
			got.last = eo.frame_last;
			sb.check_word(got);
		end
	end

	// Idle levels follow the amount of stimulus already sent: first a slow
	// receiver, then a slow sender, then full throughput on both sides.
	task automatic pick_idling();
		if (pixels_sent < 330) begin
			sender_idle_pct = 7;
			receiver_idle_pct = 52;
		end else if (pixels_sent < 660) begin
			sender_idle_pct = 52;
			receiver_idle_pct = 7;
		end else begin
			sender_idle_pct = 0;
			receiver_idle_pct = 0;
		end
	endtask

	task automatic write_size(logic index, logic [gnms_pkg::HGT_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_size(index, value);
	endtask

	// Registers change only with the core idle: all words in, then settle.
	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixel(logic [10:0] grad [6]);
		pick_idling();
		// Once, mid-frame, the sender holds back until all words are out.
		if (!held_for_drain && pixels_sent == 300) begin
			held_for_drain = 1;
			pix.valid <= 1'b0;
			while (sb.pending() != 0) @(posedge clk);
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.x_red <= grad[0];
		pix.y_red <= grad[1];
		pix.x_green <= grad[2];
		pix.y_green <= grad[3];
		pix.x_blue <= grad[4];
		pix.y_blue <= grad[5];
		do @(posedge clk); while (!pix.ready);
		sb.note_pixel(grad);
		pixels_sent++;
	endtask

	function automatic logic [10:0] draw_gradient(int style);
		case (style)
			0: return 11'($urandom_range(2047));
			1: return 11'($urandom_range(15));
			2: return 11'd0;
			default: return 11'($urandom_range(2047, 1900));
		endcase
	endfunction

	// Frames mix textures per pixel so that strong ridges and flat areas
	// both reach the window.
	task automatic send_frame_pixels(int unsigned count);
		logic [10:0] grad [6];
		int style;
		for (int unsigned n = 0; n < count; n++) begin
			style = $urandom_range(3);
			foreach (grad[i])
				grad[i] = draw_gradient(($urandom_range(9) < 7) ? style : $urandom_range(3));
			send_pixel(grad);
		end
		pix.valid <= 1'b0;
	endtask

	task automatic send_directed();
		logic [10:0] grad [6];
		int unsigned pairs [18][2] = '{
			'{0, 0}, '{2047, 2047}, '{2047, 0}, '{0, 2047}, '{1000, 414},
			'{1000, 415}, '{800, 1931}, '{800, 1932}, '{1, 0}, '{0, 1},
			'{1024, 1024}, '{5, 2047}, '{2047, 848}, '{2047, 847}, '{1365, 682},
			'{3, 7}, '{7, 3}, '{2047, 2047}};
		for (int n = 0; n < 18; n++) begin
			for (int ch = 0; ch < 3; ch++) begin
				// Rotate the pairs across colors so every lane sees each case.
				grad[2*ch] = 11'(pairs[(n + 6*ch) % 18][0]);
				grad[2*ch+1] = 11'(pairs[(n + 6*ch) % 18][1]);
			end
			send_pixel(grad);
		end
		pix.valid <= 1'b0;
	endtask

	initial begin
		int unsigned w, h;
		sb = new();
		cycle_count = 0;
		pixels_sent = 0;
		held_for_drain = 0;
		sender_idle_pct = 7;
		receiver_idle_pct = 52;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gnms_pkg::CFG_WIDTH;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.x_red = '0;
		pix.y_red = '0;
		pix.x_green = '0;
		pix.y_green = '0;
		pix.x_blue = '0;
		pix.y_blue = '0;
		eo.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sizes below the minimum act as 3x3, two frames of
		// extreme and boundary gradients.
		write_size(gnms_pkg::CFG_WIDTH, 12'd0);
		write_size(gnms_pkg::CFG_HEIGHT, 12'd2);
		send_directed();
		wait_drained();

		// Small random frames, exact minimum included.
		while (pixels_sent < 700) begin
			w = $urandom_range(12, 3);
			h = $urandom_range(9, 1);
			write_size(gnms_pkg::CFG_WIDTH, 12'(w));
			write_size(gnms_pkg::CFG_HEIGHT, 12'(h));
			send_frame_pixels(((w < 3) ? 3 : w) * ((h < 3) ? 3 : h));
			wait_drained();
		end

		// Tallest frame, narrow; only its top part is streamed.
		write_size(gnms_pkg::CFG_WIDTH, 12'd3);
		write_size(gnms_pkg::CFG_HEIGHT, 12'd4095);
		send_frame_pixels(3 * 80);
		wait_drained();

		$display("%0d pixels streamed, %0d words checked, %0d with edges, %0d frame ends",
			pixels_sent, sb.words_checked, sb.nonzero_edges, sb.frames_closed);
		$display("frames from 3x3 up to 12x9 plus a narrow 4095-row one, undersized values included");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d words missing", sb.mismatches, sb.pending());
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
src/gnms_pkg.sv
src/gnms_if.sv
src/gnms_ram.sv
src/gnms_lane.sv
src/gradient_nonmax_suppression_core.sv
tb/tb_gnms_scoreboard.sv
tb/tb_gradient_nonmax_suppression_core.sv
